### src/cs_pkg.sv
// Shared types and constants for the cosine similarity stream block.
// Depends on nothing; cs_ifs, cs_ctrl, cs_dp and the top level use it.
`default_nettype none

package cs_pkg;

	// Result format: signed Q1.15.
	localparam int SIM_W      = 16;
	localparam int FRAC_BITS  = 15;
	localparam int DIV_STEPS  = SIM_W;
	localparam logic [SIM_W-1:0] SIM_NEG_ONE = 16'h8000;
	localparam logic [SIM_W-1:0] SIM_POS_MAX = 16'h7FFF;
	localparam logic [SIM_W:0]   QUO_NEG_LIM = 17'd32768;
	localparam logic [SIM_W:0]   QUO_POS_LIM = 17'd32767;

	// A dot magnitude at or above 2^49 would overflow a 64-bit word once
	// shifted left by the fraction width, so its quotient saturates.
	localparam int HUGE_SHIFT = 64 - FRAC_BITS;

	// Upper bound of the accumulator width.
	localparam int ACC_W_MAX = 64;

	typedef struct packed {
		logic take;       // element pair request accepted this cycle
		logic fold;       // close the vector: final sums, clear accumulators
		logic sqrt_step;  // one digit of both square roots
		logic mul;        // multiply the two roots, take |dot|
		logic prep;       // saturation check and divider setup
		logic div_step;   // one quotient bit
		logic load_out;   // write the result register
	} cs_cmd_t;

	typedef struct packed {
		logic degen;      // valid while fold is high
	} cs_stat_t;

endpackage

`default_nettype wire

### src/cs_ifs.sv
// Handshake channels of the cosine similarity stream block.
// Depends on cs_pkg for the result width.
`default_nettype none

interface cs_pair_if #(parameter int ELEM_WIDTH = 16);
	logic                  valid;
	logic                  ready;
	logic [ELEM_WIDTH-1:0] elem_a;
	logic [ELEM_WIDTH-1:0] elem_b;
	logic                  last;

	modport source (output valid, output elem_a, output elem_b, output last, input ready);
	modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface cs_result_if;
	logic                     valid;
	logic                     ready;
	logic [cs_pkg::SIM_W-1:0] similarity;
	logic                     degenerate;

	modport source (output valid, output similarity, output degenerate, input ready);
	modport sink   (input valid, input similarity, input degenerate, output ready);
endinterface

`default_nettype wire

### src/cs_isqrt.sv
// Iterative integer square root (floor), one result bit per step.
// Depends on nothing outside this file.
`default_nettype none

module cs_isqrt #(
	parameter int VAL_W = 44
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          step,
	input  logic [VAL_W-1:0]              value,
	output logic [(VAL_W+(VAL_W%2))/2-1:0] root
);
	localparam int SQ_W   = VAL_W + (VAL_W % 2);
	localparam int ROOT_W = SQ_W / 2;

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W:0]   trial;
	logic            fits;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign fits  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= SQ_W'(value);
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (step) begin
			if (fits) begin
				rem_q <= rem_q - SQ_W'(trial);
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[ROOT_W-1:0];

endmodule

`default_nettype wire

### src/cs_ctrl.sv
// Sequencer of the cosine similarity block: accumulate, roots, divide, output.
// Depends on cs_pkg for the command and status structs.
`default_nettype none

module cs_ctrl #(
	parameter int ROOT_W = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pair_valid,
	input  logic             pair_last,
	output logic             pair_ready,
	output logic             res_valid,
	input  logic             res_ready,
	output cs_pkg::cs_cmd_t  cmd,
	input  cs_pkg::cs_stat_t stat
);
	import cs_pkg::*;

	localparam int STEPS_MAX = (ROOT_W > DIV_STEPS) ? ROOT_W : DIV_STEPS;
	localparam int STEP_W    = $clog2(STEPS_MAX);

	typedef enum logic [6:0] {
		ST_ACC  = 7'b0000001,
		ST_FOLD = 7'b0000010,
		ST_SQRT = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_PREP = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_DONE = 7'b1000000
	} cs_state_t;

	cs_state_t         state_q, state_nx;
	logic [STEP_W-1:0] step_q;
	logic              res_valid_q;
	logic              take;
	logic              out_free;

	assign pair_ready = (state_q == ST_ACC);
	assign take       = pair_valid && pair_ready;
	assign out_free   = !res_valid_q || res_ready;
	assign res_valid  = res_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_ACC:  if (take && pair_last) state_nx = ST_FOLD;
			ST_FOLD: state_nx = stat.degen ? ST_DONE : ST_SQRT;
			ST_SQRT: if (step_q == '0) state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_PREP;
			ST_PREP: state_nx = ST_DIV;
			ST_DIV:  if (step_q == '0) state_nx = ST_DONE;
			ST_DONE: if (out_free) state_nx = ST_ACC;
			default: state_nx = ST_ACC;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.take      = take;
		cmd.fold      = (state_q == ST_FOLD);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.mul       = (state_q == ST_MUL);
		cmd.prep      = (state_q == ST_PREP);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.load_out  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_FOLD) begin
				step_q <= STEP_W'(ROOT_W - 1);
			end else if (state_q == ST_PREP) begin
				step_q <= STEP_W'(DIV_STEPS - 1);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### src/cs_dp.sv
// Datapath of the cosine similarity block: multiply-accumulate, two square
// root units, root product, restoring divider and result register.
// Depends on cs_pkg and cs_isqrt.
`default_nettype none

module cs_dp #(
	parameter int ELEM_WIDTH = 16,
	parameter int MAX_LEN    = 4096,
	parameter int ACC_W      = 44,
	parameter int CNT_W      = 13
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [ELEM_WIDTH-1:0]    elem_a,
	input  logic [ELEM_WIDTH-1:0]    elem_b,
	input  cs_pkg::cs_cmd_t          cmd,
	output cs_pkg::cs_stat_t         stat,
	output logic [cs_pkg::SIM_W-1:0] similarity,
	output logic                     degenerate
);
	import cs_pkg::*;

	localparam int PROD_W = 2 * ELEM_WIDTH;
	localparam int SQ_W   = ACC_W + (ACC_W % 2);
	localparam int ROOT_W = SQ_W / 2;
	localparam int DEN_W  = 2 * ROOT_W;

	// Stage 1: products.
	logic signed [PROD_W-1:0] prod_ab_s1, prod_aa_s1, prod_bb_s1;
	logic                     take_s1;

	// Accumulators.
	logic signed [ACC_W-1:0] dot_q;
	logic        [ACC_W-1:0] norm_a_q, norm_b_q;
	logic        [CNT_W-1:0] cnt_q;
	logic signed [ACC_W-1:0] dot_add;
	logic        [ACC_W-1:0] norm_a_add, norm_b_add;
	logic signed [ACC_W-1:0] dot_fin;
	logic        [ACC_W-1:0] norm_a_fin, norm_b_fin;

	// Closing arithmetic.
	logic signed [ACC_W-1:0]  dot_fin_q;
	logic                     degen_q;
	logic [ROOT_W-1:0]        root_a, root_b;
	logic [DEN_W-1:0]         den_q;
	logic                     neg_q;
	logic [ACC_W-1:0]         mag_q;
	logic                     sat_q;
	logic [DEN_W-1:0]         rem_q;
	logic [SIM_W-1:0]         nbits_q;
	logic [SIM_W-1:0]         quo_q;
	logic [DEN_W:0]           trial;
	logic                     ge;
	logic [SIM_W:0]           qmag;
	logic [SIM_W-1:0]         sim_nx;
	logic [SIM_W-1:0]         sim_q;
	logic                     degen_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1 <= 1'b0;
		end else begin
			take_s1 <= cmd.take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			prod_ab_s1 <= $signed(elem_a) * $signed(elem_b);
			prod_aa_s1 <= $signed(elem_a) * $signed(elem_a);
			prod_bb_s1 <= $signed(elem_b) * $signed(elem_b);
		end
	end

	assign dot_add    = take_s1 ? ACC_W'(prod_ab_s1) : '0;
	assign norm_a_add = take_s1 ? ACC_W'($unsigned(prod_aa_s1)) : '0;
	assign norm_b_add = take_s1 ? ACC_W'($unsigned(prod_bb_s1)) : '0;
	assign dot_fin    = dot_q + dot_add;
	assign norm_a_fin = norm_a_q + norm_a_add;
	assign norm_b_fin = norm_b_q + norm_b_add;

	assign stat.degen = (cnt_q > CNT_W'(MAX_LEN)) || (norm_a_fin == '0) || (norm_b_fin == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q    <= '0;
			norm_a_q <= '0;
			norm_b_q <= '0;
			cnt_q    <= '0;
		end else if (cmd.fold) begin
			dot_q    <= '0;
			norm_a_q <= '0;
			norm_b_q <= '0;
			cnt_q    <= '0;
		end else begin
			dot_q    <= dot_fin;
			norm_a_q <= norm_a_fin;
			norm_b_q <= norm_b_fin;
			if (cmd.take && (cnt_q <= CNT_W'(MAX_LEN))) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	cs_isqrt #(.VAL_W(ACC_W)) u_sqrt_a (
		.clk   (clk),
		.load  (cmd.fold),
		.step  (cmd.sqrt_step),
		.value (norm_a_fin),
		.root  (root_a)
	);

	cs_isqrt #(.VAL_W(ACC_W)) u_sqrt_b (
		.clk   (clk),
		.load  (cmd.fold),
		.step  (cmd.sqrt_step),
		.value (norm_b_fin),
		.root  (root_b)
	);

	assign trial = {rem_q, nbits_q[SIM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.fold) begin
			dot_fin_q <= dot_fin;
			degen_q   <= stat.degen;
		end
		if (cmd.mul) begin
			den_q <= DEN_W'(root_a) * DEN_W'(root_b);
			neg_q <= dot_fin_q[ACC_W-1];
			mag_q <= dot_fin_q[ACC_W-1] ? $unsigned(-dot_fin_q) : $unsigned(dot_fin_q);
		end
		if (cmd.prep) begin
			// Quotient of 2^16 or more (or a dot too large to shift) saturates.
			sat_q   <= (|(mag_q >> HUGE_SHIFT)) ||
				({1'b0, DEN_W'(mag_q)} >= {den_q, 1'b0});
			rem_q   <= DEN_W'(mag_q >> 1);
			nbits_q <= {mag_q[0], {FRAC_BITS{1'b0}}};
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q   <= {quo_q[SIM_W-2:0], ge};
			nbits_q <= nbits_q << 1;
		end
		if (cmd.load_out) begin
			sim_q       <= sim_nx;
			degen_out_q <= degen_q;
		end
	end

	always_comb begin
		qmag   = {1'b0, quo_q};
		sim_nx = quo_q;
		if (degen_q) begin
			sim_nx = SIM_NEG_ONE;
		end else if (neg_q) begin
			if (sat_q || (qmag > QUO_NEG_LIM)) begin
				qmag = QUO_NEG_LIM;
			end
			sim_nx = SIM_W'((SIM_W+1)'(0) - qmag);
		end else if (sat_q || (qmag > QUO_POS_LIM)) begin
			sim_nx = SIM_POS_MAX;
		end
	end

	assign similarity = sim_q;
	assign degenerate = degen_out_q;

endmodule

`default_nettype wire

### src/cosine_similarity_stream.sv
// Cosine similarity of two vectors streamed as element pairs. Uses cs_pkg, cs_ifs,
// cs_ctrl, cs_dp and cs_isqrt.
// Throughput: one pair per cycle while accumulating. The pair marked last stalls the
// input while it folds the sums, takes ROOT_W root steps, multiplies the roots and runs
// the 16 divider steps; degenerate vectors skip from the fold to the output register.
// Reset (arst_n low, asynchronous) clears the accumulators and the result valid flag.
`default_nettype none

module cosine_similarity_stream #(
	parameter int MAX_LEN    = 4096,
	parameter int ELEM_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cs_pair_if.sink     pair,
	cs_result_if.source result
);
	import cs_pkg::*;

	// The dot product of MAX_LEN full-scale pairs needs 2*ELEM_WIDTH-2 bits of
	// product, the bits of the count, and a sign. The width is capped at 64 bits, beyond
	// which the sums of a long vector of large elements can wrap.
	localparam int ACC_RAW = 2 * ELEM_WIDTH - 1 + $clog2(MAX_LEN + 1);
	localparam int ACC_W   = (ACC_RAW > ACC_W_MAX) ? ACC_W_MAX : ACC_RAW;
	localparam int SQ_W    = ACC_W + (ACC_W % 2);
	localparam int ROOT_W  = SQ_W / 2;
	// The count holds at MAX_LEN + 1 once the vector is too long.
	localparam int CNT_W   = $clog2(MAX_LEN + 2);

	cs_cmd_t  cmd;
	cs_stat_t stat;
	logic     pair_ready;
	logic     res_valid;

	// The controller owns the handshakes and the sequence of the closing
	// arithmetic; the datapath only follows its commands.
	cs_ctrl #(.ROOT_W(ROOT_W)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair.valid),
		.pair_last  (pair.last),
		.pair_ready (pair_ready),
		.res_valid  (res_valid),
		.res_ready  (result.ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	// The datapath multiplies each request's elements, accumulates the dot
	// product and both squared norms, and on the last request works out the
	// similarity into the result register.
	cs_dp #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.MAX_LEN    (MAX_LEN),
		.ACC_W      (ACC_W),
		.CNT_W      (CNT_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_a     (pair.elem_a),
		.elem_b     (pair.elem_b),
		.cmd        (cmd),
		.stat       (stat),
		.similarity (result.similarity),
		.degenerate (result.degenerate)
	);

	assign pair.ready   = pair_ready;
	assign result.valid = res_valid;

endmodule

`default_nettype wire

### src/cs_checker.sv
// Port-level checks of the cosine similarity block, bound to the top level.
// Depends on cosine_similarity_stream and its interfaces.
`default_nettype none

module cs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pair_valid,
	input logic        pair_ready,
	input logic        pair_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] similarity,
	input logic        degenerate
);

	// Once the last request is taken, the closing arithmetic always takes the input off.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_ready && pair_last |=> !pair_ready)
		else $error("input still ready right after the last request");

	// A degenerate result always reads as minus one.
	a_degen_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && degenerate |-> similarity == 16'h8000)
		else $error("degenerate result is not -1.0");

	// A result that waits keeps its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			res_valid && $stable(similarity) && $stable(degenerate))
		else $error("waiting result changed or vanished");

endmodule

bind cosine_similarity_stream cs_checker u_cs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pair_valid (pair.valid),
	.pair_ready (pair.ready),
	.pair_last  (pair.last),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.similarity (result.similarity),
	.degenerate (result.degenerate)
);

`default_nettype wire
